// ----- design/bgc_pkg.sv -----
// Shared types and constants for the button gesture classifier.
// Holds the event and state codes, register indexes and the config record.
// No dependencies.
package bgc_pkg;

	localparam int unsigned TICK_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned CNT_W  = 8;
	localparam int unsigned IDX_W  = 3;

	localparam logic [CNT_W-1:0] CLICK_MAX = '1;

	typedef enum logic [1:0] {
		EDGE_NONE    = 2'd0,
		EDGE_PRESS   = 2'd1,
		EDGE_RELEASE = 2'd2
	} edge_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_CLICK       = 3'd1,
		EV_HOLD        = 3'd2,
		EV_HOLD_REPEAT = 3'd3,
		EV_LONG_HOLD   = 3'd4,
		EV_LONG_REPEAT = 3'd5
	} gesture_t;

	typedef enum logic [1:0] {
		ST_RELEASED = 2'd0,
		ST_PRESSED  = 2'd1,
		ST_HOLD     = 2'd2,
		ST_LONG     = 2'd3
	} bstate_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_CLICK_GAP   = 3'd1,
		REG_HOLD        = 3'd2,
		REG_LONG_HOLD   = 3'd3,
		REG_HOLD_REPEAT = 3'd4,
		REG_LONG_REPEAT = 3'd5
	} reg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd20;
	localparam logic [CFG_W-1:0] CLICK_GAP_RST   = 16'd250;
	localparam logic [CFG_W-1:0] HOLD_RST        = 16'd500;
	localparam logic [CFG_W-1:0] LONG_HOLD_RST   = 16'd2000;
	localparam logic [CFG_W-1:0] HOLD_REPEAT_RST = 16'd100;
	localparam logic [CFG_W-1:0] LONG_REPEAT_RST = 16'd50;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] click_gap_time;
		logic [CFG_W-1:0] hold_time;
		logic [CFG_W-1:0] long_hold_time;
		logic [CFG_W-1:0] hold_repeat_time;
		logic [CFG_W-1:0] long_repeat_time;
	} cfg_t;

	typedef struct packed {
		edge_t edge_evt;
		logic  level;
	} deb_out_t;

	typedef struct packed {
		gesture_t          gesture;
		logic [CNT_W-1:0]  clicks;
		bstate_t           state;
	} cls_out_t;

endpackage

// ----- design/bgc_debounce.sv -----
// Debounce stage: accepted level and the stamp of the last agreeing sample.
// Depends on bgc_pkg.
module bgc_debounce (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         raw,
	input  logic [bgc_pkg::TICK_W-1:0]   now,
	input  logic [bgc_pkg::CFG_W-1:0]    debounce_time,
	output bgc_pkg::deb_out_t            result
);

	logic                       level_q;
	logic [bgc_pkg::TICK_W-1:0] stamp_q;
	logic [bgc_pkg::TICK_W-1:0] elapsed;
	logic                       agree;
	logic                       expired;

	assign elapsed = now - stamp_q;
	assign agree   = (raw == level_q);
	assign expired = elapsed >= {{(bgc_pkg::TICK_W-bgc_pkg::CFG_W){1'b0}}, debounce_time};

	always_comb begin
		result.level    = level_q;
		result.edge_evt = bgc_pkg::EDGE_NONE;
		if (!agree && expired) begin
			result.level    = ~level_q;
			result.edge_evt = level_q ? bgc_pkg::EDGE_RELEASE : bgc_pkg::EDGE_PRESS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			stamp_q <= '0;
		end else if (en) begin
			level_q <= result.level;
			// The stamp follows the sample whenever it agrees or a change is taken.
			if (agree || expired) begin
				stamp_q <= now;
			end
		end
	end

endmodule

// ----- design/bgc_classifier.sv -----
// Gesture state machine: released, pressed, hold and long hold.
// Keeps the click counter and the press and repeat stamps. Depends on bgc_pkg.
module bgc_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         level,
	input  logic [bgc_pkg::TICK_W-1:0]   now,
	input  bgc_pkg::cfg_t                cfg,
	output bgc_pkg::cls_out_t            result
);

	localparam int unsigned PAD_W = bgc_pkg::TICK_W - bgc_pkg::CFG_W;

	bgc_pkg::bstate_t           state_q, state_d;
	logic [bgc_pkg::TICK_W-1:0] press_q, press_d;
	logic [bgc_pkg::TICK_W-1:0] repeat_q, repeat_d;
	logic [bgc_pkg::CNT_W-1:0]  clicks_q, clicks_d;
	logic [bgc_pkg::TICK_W-1:0] since_press;
	logic [bgc_pkg::TICK_W-1:0] since_repeat;
	bgc_pkg::gesture_t          gesture;

	assign since_press  = now - press_q;
	assign since_repeat = now - repeat_q;

	always_comb begin
		state_d  = state_q;
		press_d  = press_q;
		repeat_d = repeat_q;
		clicks_d = clicks_q;
		gesture  = bgc_pkg::EV_NONE;
		case (state_q)
			bgc_pkg::ST_RELEASED: begin
				if (!level) begin
					if (clicks_q != '0 &&
					    since_press > {{PAD_W{1'b0}}, cfg.click_gap_time}) begin
						gesture  = bgc_pkg::EV_CLICK;
						clicks_d = '0;
					end
				end else begin
					state_d = bgc_pkg::ST_PRESSED;
					press_d = now;
				end
			end
			bgc_pkg::ST_PRESSED: begin
				if (!level) begin
					if (clicks_q != bgc_pkg::CLICK_MAX) begin
						clicks_d = clicks_q + 1'b1;
					end
					state_d = bgc_pkg::ST_RELEASED;
				end else if (since_press >= {{PAD_W{1'b0}}, cfg.hold_time}) begin
					gesture  = bgc_pkg::EV_HOLD;
					press_d  = now;
					repeat_d = now;
					state_d  = bgc_pkg::ST_HOLD;
				end
			end
			bgc_pkg::ST_HOLD: begin
				if (!level) begin
					state_d  = bgc_pkg::ST_RELEASED;
					clicks_d = '0;
				end else if (since_press < {{PAD_W{1'b0}}, cfg.long_hold_time}) begin
					if (since_repeat >= {{PAD_W{1'b0}}, cfg.hold_repeat_time}) begin
						gesture  = bgc_pkg::EV_HOLD_REPEAT;
						repeat_d = now;
					end
				end else begin
					gesture  = bgc_pkg::EV_LONG_HOLD;
					press_d  = now;
					repeat_d = now;
					state_d  = bgc_pkg::ST_LONG;
				end
			end
			default: begin
				// Long hold: a release goes straight back with no repeat event.
				if (!level) begin
					state_d  = bgc_pkg::ST_RELEASED;
					clicks_d = '0;
				end else if (since_repeat >= {{PAD_W{1'b0}}, cfg.long_repeat_time}) begin
					gesture  = bgc_pkg::EV_LONG_REPEAT;
					repeat_d = now;
				end
			end
		endcase
	end

	assign result.gesture = gesture;
	assign result.clicks  = clicks_q;
	assign result.state   = state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bgc_pkg::ST_RELEASED;
			press_q  <= '0;
			repeat_q <= '0;
			clicks_q <= '0;
		end else if (en) begin
			state_q  <= state_d;
			press_q  <= press_d;
			repeat_q <= repeat_d;
			clicks_q <= clicks_d;
		end
	end

endmodule

// ----- design/button_gesture_classifier.sv -----
// Button gesture classifier top level: config registers, input and result registers.
// A beat passes through the input register, then the result register, to the master side.
// One beat per cycle unless m_tready is low; an empty input register still takes a beat.
// The debounce and gesture state update in the cycle the input register hands on its beat.
// Reset (arst_n low, asynchronous) empties both registers, clears the debounce
// and gesture state and loads the default timing values.
module button_gesture_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bgc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bgc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,  // raw_pressed, now_ticks[31:0], 7 zero bits
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata   // edge_event[1:0], gesture_event[2:0],
	                                                // click_count[7:0], debounced_level,
	                                                // button_state[1:0]
);

	bgc_pkg::cfg_t              cfg_q;
	logic                       valid_s1;
	logic                       raw_s1;
	logic [bgc_pkg::TICK_W-1:0] now_s1;
	logic                       valid_s2;
	logic [15:0]                data_s2;
	logic                       advance;
	logic                       any_event;
	logic [bgc_pkg::CNT_W-1:0]  count_out;
	bgc_pkg::deb_out_t          deb;
	bgc_pkg::cls_out_t          cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time    <= bgc_pkg::DEBOUNCE_RST;
			cfg_q.click_gap_time   <= bgc_pkg::CLICK_GAP_RST;
			cfg_q.hold_time        <= bgc_pkg::HOLD_RST;
			cfg_q.long_hold_time   <= bgc_pkg::LONG_HOLD_RST;
			cfg_q.hold_repeat_time <= bgc_pkg::HOLD_REPEAT_RST;
			cfg_q.long_repeat_time <= bgc_pkg::LONG_REPEAT_RST;
		end else if (cfg_wr_en) begin
			case (bgc_pkg::reg_idx_t'(cfg_index))
				bgc_pkg::REG_DEBOUNCE:    cfg_q.debounce_time    <= cfg_data;
				bgc_pkg::REG_CLICK_GAP:   cfg_q.click_gap_time   <= cfg_data;
				bgc_pkg::REG_HOLD:        cfg_q.hold_time        <= cfg_data;
				bgc_pkg::REG_LONG_HOLD:   cfg_q.long_hold_time   <= cfg_data;
				bgc_pkg::REG_HOLD_REPEAT: cfg_q.hold_repeat_time <= cfg_data;
				bgc_pkg::REG_LONG_REPEAT: cfg_q.long_repeat_time <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held beat moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1 <= s_tdata[0];
			now_s1 <= s_tdata[32:1];
		end
	end

	bgc_debounce u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.raw           (raw_s1),
		.now           (now_s1),
		.debounce_time (cfg_q.debounce_time),
		.result        (deb)
	);

	bgc_classifier u_classifier (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.level  (deb.level),
		.now    (now_s1),
		.cfg    (cfg_q),
		.result (cls)
	);

	assign any_event = (deb.edge_evt != bgc_pkg::EDGE_NONE) || (cls.gesture != bgc_pkg::EV_NONE);
	assign count_out = any_event ? cls.clicks : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {cls.state, deb.level, count_out, cls.gesture, deb.edge_evt};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

`ifndef NO_ASSERTIONS
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:2] == bgc_pkg::EV_HOLD |-> m_tdata[15:14] == bgc_pkg::ST_HOLD)
		else $error("hold event without hold state");

	a_long_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[4:2] == bgc_pkg::EV_LONG_HOLD ||
		             m_tdata[4:2] == bgc_pkg::EV_LONG_REPEAT)
		|-> m_tdata[15:14] == bgc_pkg::ST_LONG)
		else $error("long hold event outside long hold state");

	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == bgc_pkg::EDGE_PRESS |-> m_tdata[13])
		else $error("pressed edge with released level");

	a_quiet_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == bgc_pkg::EDGE_NONE && m_tdata[4:2] == bgc_pkg::EV_NONE
		|-> m_tdata[12:5] == '0)
		else $error("click count shown without an event");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while input register empty");
`endif

endmodule
